// File: design/vdct_pkg.sv
// vdct_pkg: types, codes and sizes shared by the vertex weld table
// no dependencies; imported by vertex_dedup_chained_table

package vdct_pkg;

   // table geometry
   localparam int TABLE_SLOTS = 4096;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int BASE_W      = SLOT_W + 1;

   // item kinds
   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [11:0] position_index;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] norm_x;
      logic [31:0] norm_y;
      logic [31:0] norm_z;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
      logic [31:0] color;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] vertex_index;
      logic        created;
      logic [1:0]  status;
   } rsp_payload_type;

   // per-slot chain bookkeeping
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] link;
   } slot_meta_type;

   // per-slot attributes, first word in the low half
   typedef struct packed {
      logic [63:0] pos_xy;
      logic [63:0] posz_normx;
      logic [63:0] norm_yz;
      logic [63:0] uv;
      logic [31:0] color;
   } slot_data_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_APPEND,
      S_DONE
   } state_type;

endpackage

// File: design/vertex_dedup_chained_table.sv
// vertex_dedup_chained_table: vertex weld table with chained collision slots
// depends on vdct_pkg for payload types, status codes and table size

// Welds mesh vertices one transaction at a time. A start transaction sweeps
// the slot bookkeeping memory, clearing every valid mark and link (one
// slot a cycle), sets the append pointer to base_count, capped at the
// table size, and then answers; the same sweep runs after reset, during
// which no transaction is taken (csr writes still are). A lookup
// transaction reads and checks the head slot, then each further chain
// slot visited, and writes a new slot when one is appended: each visit
// is one read of the two slot memories (one read and one write port each,
// registered read) and one compare. An index at or past base_count
// answers with status range. The result sits in an output register, so
// the next transaction is taken while it waits.
module vertex_dedup_chained_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  vdct_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output vdct_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [12:0]               csr_wr_data
);
   import vdct_pkg::*;

   // the two slot memories
   slot_meta_type slot_meta_mem [TABLE_SLOTS];
   slot_data_type slot_data_mem [TABLE_SLOTS];

   state_type         state_ff, state_in;
   req_payload_type   item_ff;
   rsp_payload_type   res_ff;
   rsp_payload_type   rsp_payload_ff;
   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] cur_ff;
   logic [SLOT_W-1:0] steps_ff;
   logic [SLOT_W-1:0] clr_addr_ff;
   logic              clr_reply_ff;
   logic [BASE_W-1:0] append_ptr_ff;
   logic [12:0]       base_count_ff;

   slot_meta_type     meta_rd_ff;
   slot_data_type     data_rd_ff;

   // memory port controls
   logic              meta_we;
   logic              data_we;
   logic [SLOT_W-1:0] wr_addr;
   logic [SLOT_W-1:0] rd_addr;
   slot_meta_type     meta_wr;
   slot_data_type     item_data;

   logic [BASE_W-1:0] eff_base;
   logic              req_take;
   logic              out_free;
   logic              out_range;
   logic              clr_last;

   // chain walk decisions, meaningful in the check state
   logic              chk_fill;
   logic              chk_hit;
   logic              chk_follow;
   logic              chk_runaway;
   logic              chk_full;
   logic              chk_append;

   // base_count above the table size acts as the table size
   assign eff_base = (base_count_ff > BASE_W'(TABLE_SLOTS)) ?
                     BASE_W'(TABLE_SLOTS) : base_count_ff;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_range = {1'b0, req_payload.position_index} >= eff_base;
   assign clr_last  = clr_addr_ff == SLOT_W'(TABLE_SLOTS - 1);

   assign item_data.pos_xy     = {item_ff.pos_y, item_ff.pos_x};
   assign item_data.posz_normx = {item_ff.norm_x, item_ff.pos_z};
   assign item_data.norm_yz    = {item_ff.norm_z, item_ff.norm_y};
   assign item_data.uv         = {item_ff.tex_v, item_ff.tex_u};
   assign item_data.color      = item_ff.color;

   // empty slot is filled, equal slot answers, otherwise follow, append or report full
   assign chk_fill    = !meta_rd_ff.valid;
   assign chk_hit     = meta_rd_ff.valid && (data_rd_ff == item_data);
   assign chk_follow  = meta_rd_ff.valid && !chk_hit && (meta_rd_ff.link != '0);
   assign chk_runaway = chk_follow && (steps_ff == SLOT_W'(TABLE_SLOTS - 1));
   assign chk_full    = meta_rd_ff.valid && !chk_hit && (meta_rd_ff.link == '0) &&
                        (append_ptr_ff >= BASE_W'(TABLE_SLOTS));
   assign chk_append  = meta_rd_ff.valid && !chk_hit && (meta_rd_ff.link == '0) &&
                        !chk_full;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = clr_reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_payload.kind == KIND_START) begin
                  state_in = S_CLEAR;
               end else if (out_range) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (chk_follow && !chk_runaway) begin
               state_in = S_READ;
            end else if (chk_append) begin
               state_in = S_APPEND;
            end else begin
               state_in = S_DONE;
            end
         end
         S_APPEND: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state machine outputs: handshake and memory ports
   always_comb begin
      req_stall = 1'b1;
      rd_addr   = cur_ff;
      meta_we   = 1'b0;
      data_we   = 1'b0;
      wr_addr   = cur_ff;
      meta_wr   = '0;
      case (state_ff)
         S_CLEAR: begin
            meta_we = 1'b1;
            wr_addr = clr_addr_ff;
         end
         S_IDLE: begin
            // head slot read issued with the transaction itself
            req_stall = 1'b0;
            rd_addr   = req_payload.position_index;
         end
         S_CHECK: begin
            if (chk_fill) begin
               meta_we      = 1'b1;
               data_we      = 1'b1;
               meta_wr      = meta_rd_ff;
               meta_wr.valid = 1'b1;
            end else if (chk_append) begin
               // link the chain end to the new slot
               meta_we      = 1'b1;
               meta_wr.valid = 1'b1;
               meta_wr.link  = append_ptr_ff[SLOT_W-1:0];
            end
         end
         S_APPEND: begin
            // new slot ends its chain
            meta_we       = 1'b1;
            data_we       = 1'b1;
            wr_addr       = append_ptr_ff[SLOT_W-1:0];
            meta_wr.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // slot memories, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (meta_we) begin
         slot_meta_mem[wr_addr] <= meta_wr;
      end
      meta_rd_ff <= slot_meta_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         slot_data_mem[wr_addr] <= item_data;
      end
      data_rd_ff <= slot_data_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         clr_reply_ff  <= 1'b0;
         append_ptr_ff <= '0;
         base_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         steps_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            base_count_ff <= csr_wr_data;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
            S_IDLE: begin
               if (req_take && req_payload.kind == KIND_START) begin
                  append_ptr_ff <= eff_base;
                  clr_addr_ff   <= '0;
                  clr_reply_ff  <= 1'b1;
               end
               steps_ff <= '0;
            end
            S_CHECK: begin
               if (chk_follow) begin
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_APPEND: begin
               append_ptr_ff <= append_ptr_ff + 1'b1;
            end
            default: begin
            end
         endcase
         // output register: load a finished result, drop a taken one
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               item_ff <= req_payload;
               cur_ff  <= req_payload.position_index;
               res_ff  <= '{vertex_index: '0, created: 1'b0,
                            status: (req_payload.kind == KIND_LOOKUP && out_range) ?
                                    ST_RANGE : ST_OK};
            end
         end
         S_CHECK: begin
            if (chk_fill || chk_hit) begin
               res_ff <= '{vertex_index: cur_ff, created: 1'b0, status: ST_OK};
            end else if (chk_follow && !chk_runaway) begin
               cur_ff <= meta_rd_ff.link;
            end else if (chk_append) begin
               res_ff <= '{vertex_index: append_ptr_ff[SLOT_W-1:0], created: 1'b1,
                           status: ST_OK};
            end else begin
               // table full or runaway chain
               res_ff <= '{vertex_index: '0, created: 1'b0, status: ST_FULL};
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_payload_ff <= res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // append pointer never runs past the table
   a_append_bound: assert property (@(posedge clock) disable iff (reset)
      append_ptr_ff <= BASE_W'(TABLE_SLOTS))
      else $error("append pointer past table end");

   // an append always answers with a created slot
   a_append_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPEND |-> res_ff.created && res_ff.status == ST_OK)
      else $error("append without created result");

   // a finished result waits while the output register is occupied
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_free) |=> state_ff == S_DONE && $stable(res_ff))
      else $error("pending result lost");

   // a follow-up read only happens after at least one chain step
   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> steps_ff != '0)
      else $error("chain read without step");

endmodule
